@@ hdl/aabb_fdm_pkg.sv @@
// Shared types and codes for the box sweep free-distance block.
// Holds the beat structs of both channels, register indexes and direction codes.
// No dependencies.
package aabb_fdm_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned GAP_W      = 26;
    localparam int unsigned ZSPAN_W    = 18;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SELF_ID    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_W     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_H     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_DEPTH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_DIR   = 3'd7;

    // move directions
    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    typedef struct packed {
        logic        [15:0] other_id;
        logic signed [23:0] other_x;
        logic signed [23:0] other_y;
        logic        [22:0] other_w;
        logic        [22:0] other_h;
        logic signed [15:0] other_z;
        logic        [14:0] other_depth;
        logic               last_box;
    } t_in_beat;

    typedef struct packed {
        logic signed [GAP_W-1:0] space_left;
        logic                    no_obstacle;
    } t_out_beat;

endpackage

@@ hdl/aabb_free_distance_min.sv @@
// Free distance of an axis-aligned box sweep: running minimum gap over a box stream.
// Single module; depends on aabb_fdm_pkg for beat types, register indexes and
// direction codes.
//
// Usage:
//   Write the mover box and direction through i_cfg_we/i_cfg_idx/i_cfg_wdata while
//   the block is idle. Then stream candidate boxes on the input channel
//   (i_in_valid / o_in_stall / i_in_data), marking the final one with last_box.
//   Each beat is registered, then checked against the mover and folded into the
//   running minimum in the following cycle, unless a last_box beat is held. A
//   last_box beat loads one result beat (o_out_valid / i_out_stall / o_out_data) into
//   the result register as it leaves the input register; other beats give nothing.
//   Throughput is one box per clock; the only limit is the result register, so a
//   last_box beat waits in the input register while an earlier result is stalled.
//   Non-last beats keep flowing under an output stall.
//   Reset (synchronous, i_rst_n low) clears the configuration registers, the
//   running minimum and both valid flags.
//   A stalled result holds its value until taken.
module aabb_free_distance_min
    import aabb_fdm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data
);

    // configuration
    logic        [15:0] r_self_id;
    logic signed [23:0] r_self_x;
    logic signed [23:0] r_self_y;
    logic        [22:0] r_self_w;
    logic        [22:0] r_self_h;
    logic signed [15:0] r_self_z;
    logic        [14:0] r_self_depth;
    logic        [1:0]  r_move_dir;

    // input register
    logic     r_s1_vld;
    t_in_beat r_s1;

    // sweep state
    logic signed [GAP_W-1:0] r_best_gap;
    logic                    r_any_found;
    logic signed [GAP_W-1:0] n_best_gap;
    logic                    n_any_found;

    // result register
    logic      r_out_vld;
    t_out_beat r_out;

    logic s1_adv;
    logic out_load;

    logic signed [GAP_W-1:0]   sx, sy, sx1, sy1, ox, oy, ox1, oy1, gap;
    logic signed [ZSPAN_W-1:0] sz0, sz1, oz0, oz1;
    logic                      z_meet, cross_meet, counts, take;

    // a last beat needs the result register free (or draining this cycle)
    assign s1_adv     = r_s1_vld && !(r_s1.last_box && r_out_vld && i_out_stall);
    assign out_load   = s1_adv && r_s1.last_box;
    assign o_in_stall = r_s1_vld && !s1_adv;

    always_comb begin
        sx  = {{(GAP_W-24){r_self_x[23]}}, r_self_x};
        sy  = {{(GAP_W-24){r_self_y[23]}}, r_self_y};
        sx1 = sx + {{(GAP_W-23){1'b0}}, r_self_w};
        sy1 = sy + {{(GAP_W-23){1'b0}}, r_self_h};
        ox  = {{(GAP_W-24){r_s1.other_x[23]}}, r_s1.other_x};
        oy  = {{(GAP_W-24){r_s1.other_y[23]}}, r_s1.other_y};
        ox1 = ox + {{(GAP_W-23){1'b0}}, r_s1.other_w};
        oy1 = oy + {{(GAP_W-23){1'b0}}, r_s1.other_h};
        sz0 = {{(ZSPAN_W-16){r_self_z[15]}}, r_self_z};
        sz1 = sz0 + {{(ZSPAN_W-15){1'b0}}, r_self_depth};
        oz0 = {{(ZSPAN_W-16){r_s1.other_z[15]}}, r_s1.other_z};
        oz1 = oz0 + {{(ZSPAN_W-15){1'b0}}, r_s1.other_depth};

        z_meet = (sz0 <= oz1) && (oz0 <= sz1);

        case (r_move_dir)
            DIR_RIGHT: begin
                cross_meet = (sy <= oy1) && (oy <= sy1);
                gap        = ox - sx1;
            end
            DIR_LEFT: begin
                cross_meet = (sy <= oy1) && (oy <= sy1);
                gap        = sx - ox1;
            end
            DIR_DOWN: begin
                cross_meet = (sx <= ox1) && (ox <= sx1);
                gap        = oy - sy1;
            end
            DIR_UP: begin
                cross_meet = (sx <= ox1) && (ox <= sx1);
                gap        = sy - oy1;
            end
            default: begin
                cross_meet = 1'b0;
                gap        = '0;
            end
        endcase

        counts = (r_s1.other_id != r_self_id) && z_meet && cross_meet;
        take   = counts && (!r_any_found || (gap < r_best_gap));

        n_best_gap  = take ? gap : r_best_gap;
        n_any_found = r_any_found || take;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id    <= '0;
            r_self_x     <= '0;
            r_self_y     <= '0;
            r_self_w     <= '0;
            r_self_h     <= '0;
            r_self_z     <= '0;
            r_self_depth <= '0;
            r_move_dir   <= DIR_RIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SELF_ID:    r_self_id    <= i_cfg_wdata[15:0];
                REG_SELF_X:     r_self_x     <= i_cfg_wdata[23:0];
                REG_SELF_Y:     r_self_y     <= i_cfg_wdata[23:0];
                REG_SELF_W:     r_self_w     <= i_cfg_wdata[22:0];
                REG_SELF_H:     r_self_h     <= i_cfg_wdata[22:0];
                REG_SELF_Z:     r_self_z     <= i_cfg_wdata[15:0];
                REG_SELF_DEPTH: r_self_depth <= i_cfg_wdata[14:0];
                REG_MOVE_DIR:   r_move_dir   <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1 <= i_in_data;
        end
    end

    // running minimum; restart after a last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_gap  <= '0;
            r_any_found <= 1'b0;
        end else if (s1_adv) begin
            if (r_s1.last_box) begin
                r_best_gap  <= '0;
                r_any_found <= 1'b0;
            end else begin
                r_best_gap  <= n_best_gap;
                r_any_found <= n_any_found;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.space_left  <= n_any_found ? n_best_gap : '0;
            r_out.no_obstacle <= !n_any_found;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_sweep_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (!r_any_found && r_best_gap == '0))
        else $error("sweep state not cleared after last beat");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_vld)
        else $error("result not presented after last beat");

    a_no_obstacle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.no_obstacle && r_out.space_left != '0))
        else $error("no-obstacle result carries a nonzero gap");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_vld && r_s1.last_box && r_out_vld && i_out_stall))
        else $error("input stalled without a blocked result");
`endif

endmodule
